/* rtl/core/ewbr_pkg.sv */
// ----------------------------------------------------------------------------
// ewbr_pkg
// Shared widths, CORDIC angle table and fixed-point helpers for the rotator.
// ----------------------------------------------------------------------------
package ewbr_pkg;

  localparam int AngleBits  = 16;
  localparam int VectorBits = 32;
  localparam int TrigStages = 16;
  localparam int TrigShift  = 30;
  localparam int TrigW      = 34;   // Q2.30 plus CORDIC growth headroom
  localparam int ZW         = 33;   // residual angle
  localparam int CoefW      = 34;
  localparam int ProdW      = CoefW + VectorBits;
  localparam int AccW       = ProdW + 2;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic signed [TrigW-1:0] CordicStart = TrigW'(652032874);
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    logic signed [AngleBits-1:0]  roll;
    logic signed [AngleBits-1:0]  pitch;
    logic signed [AngleBits-1:0]  yaw;
    logic signed [VectorBits-1:0] wx;
    logic signed [VectorBits-1:0] wy;
    logic signed [VectorBits-1:0] wz;
  } req_t;

  // prepared CORDIC start: residual angle and quadrant flip per axis
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 flip;
  } axis_t;

  typedef struct packed {
    axis_t                        r;
    axis_t                        p;
    axis_t                        y;
    logic signed [VectorBits-1:0] wx;
    logic signed [VectorBits-1:0] wy;
    logic signed [VectorBits-1:0] wz;
  } prep_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0: r = ZW'(536870912);  1: r = ZW'(316933406);  2: r = ZW'(167458907);
      3: r = ZW'(85004756);   4: r = ZW'(42667331);   5: r = ZW'(21354465);
      6: r = ZW'(10679838);   7: r = ZW'(5340245);    8: r = ZW'(2670163);
      9: r = ZW'(1335087);    10: r = ZW'(667544);    11: r = ZW'(333772);
      12: r = ZW'(166886);    13: r = ZW'(83443);     14: r = ZW'(41722);
      15: r = ZW'(20861);     16: r = ZW'(10430);     17: r = ZW'(5215);
      18: r = ZW'(2608);      19: r = ZW'(1304);      20: r = ZW'(652);
      21: r = ZW'(326);       22: r = ZW'(163);       default: r = ZW'(81);
    endcase
    return r;
  endfunction

  // angle prep: widen to 32-bit turn, add offset, fold quadrants 1/2
  function automatic axis_t prep_angle(input logic [AngleBits-1:0] a,
                                       input logic [31:0] off);
    logic [31:0] t;
    axis_t       o;
    t = {a, {(32-AngleBits){1'b0}}} + off;
    o.flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
    if (o.flip) t = t + HalfTurn;
    o.z = ZW'(signed'(t));
    return o;
  endfunction

  // (a*b + 2^29) >>> 30 on Q2.30
  function automatic logic signed [CoefW-1:0] mul_q30(input logic signed [CoefW-1:0] a,
                                                      input logic signed [CoefW-1:0] b);
    logic signed [2*CoefW-1:0] p;
    p = a * b + (2*CoefW)'(64'sd1 <<< (TrigShift-1));
    return CoefW'(p >>> TrigShift);
  endfunction

endpackage

/* rtl/core/euler_world_to_body_rotate_core.sv */
// ----------------------------------------------------------------------------
// euler_world_to_body_rotate_core
// World-frame to body-frame vector rotation from roll, pitch and yaw.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with roll, pitch, yaw (16-bit binary
// angles, 32768 = pi) and world x/y/z in signed Q16.16.
// Output channel: out_valid_o / out_stall_i with body x/y/z in Q16.16,
// saturated on overflow.
// Throughput: one request per cycle sustained while the receiver does not stall.
// From input accept to output valid a request passes the front queue, then
// the back end: an input register, the 16 CORDIC stages, a trig fix-up, the
// two product stages that form the nine coefficients, the coefficient times
// vector products, the row sums and the saturation register.
// A four-entry queue sits between the front (angle folding) and back
// (CORDIC and matrix) so the input keeps flowing while the back end
// holds a result.
// When the receiver stalls, the whole back pipeline freezes and the queue
// fills; in_stall_o rises only once it is full.
// Reset clears the queue count and all valid bits; no result is pending.
// ----------------------------------------------------------------------------
module euler_world_to_body_rotate_core import ewbr_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [AngleBits-1:0]  roll_angle_i,
  input  logic signed [AngleBits-1:0]  pitch_angle_i,
  input  logic signed [AngleBits-1:0]  yaw_angle_i,
  input  logic signed [VectorBits-1:0] world_x_i,
  input  logic signed [VectorBits-1:0] world_y_i,
  input  logic signed [VectorBits-1:0] world_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VectorBits-1:0] body_x_o,
  output logic signed [VectorBits-1:0] body_y_o,
  output logic signed [VectorBits-1:0] body_z_o
);
  req_t  req;
  prep_t q_data;
  logic  q_valid, q_pop;

  assign req = '{roll: roll_angle_i, pitch: pitch_angle_i, yaw: yaw_angle_i,
                 wx: world_x_i, wy: world_y_i, wz: world_z_i};

  ewbr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_i(req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  ewbr_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .body_x_o, .body_y_o, .body_z_o
  );
endmodule

/* rtl/core/ewbr_front.sv */
// ----------------------------------------------------------------------------
// ewbr_front
// Accepts requests, folds angles into the CORDIC range and queues them.
// ----------------------------------------------------------------------------
module ewbr_front import ewbr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  req_t  req_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output prep_t q_data_o
);
  prep_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push, pop;
  prep_t                prep;

  always_comb begin
    prep.r  = prep_angle(req_i.roll,  32'h0);
    prep.p  = prep_angle(req_i.pitch, 32'h0);
    prep.y  = prep_angle(req_i.yaw,   QuarterTurn);
    prep.wx = req_i.wx;
    prep.wy = req_i.wy;
    prep.wz = req_i.wz;
  end

  assign in_stall_o = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_pop_i;
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= prep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end
endmodule

/* rtl/core/ewbr_back.sv */
// ----------------------------------------------------------------------------
// ewbr_back
// CORDIC stages, coefficient products, dot products and saturation.
// ----------------------------------------------------------------------------
module ewbr_back import ewbr_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  prep_t                        q_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VectorBits-1:0] body_x_o,
  output logic signed [VectorBits-1:0] body_y_o,
  output logic signed [VectorBits-1:0] body_z_o
);
  localparam int NS = TrigStages;
  localparam int NP = NS + 7;  // total stage count
  localparam logic signed [VectorBits-1:0] VMax = {1'b0, {(VectorBits-1){1'b1}}};
  localparam logic signed [VectorBits-1:0] VMin = {1'b1, {(VectorBits-1){1'b0}}};

  logic [NP-1:0] vld_q;
  logic          adv;

  // whole pipe moves unless its last stage holds an untaken result
  assign adv         = !(vld_q[NP-1] && out_stall_i);
  assign q_pop_o     = adv;
  assign out_valid_o = vld_q[NP-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NP-2:0], q_valid_i};
  end

  // ---- CORDIC: three axes, NS stages ----
  trig_t                x_q [3][NS+1];
  trig_t                y_q [3][NS+1];
  logic signed [ZW-1:0] z_q [3][NS+1];
  logic                 f_q [3][NS+1];
  logic signed [VectorBits-1:0] w_q [3][NS+1];
  axis_t ax [3];

  assign ax[0] = q_data_i.r;
  assign ax[1] = q_data_i.p;
  assign ax[2] = q_data_i.y;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        x_q[a][0] <= CordicStart;
        y_q[a][0] <= '0;
        z_q[a][0] <= ax[a].z;
        f_q[a][0] <= ax[a].flip;
        for (int s = 0; s < NS; s++) begin
          if (!z_q[a][s][ZW-1]) begin
            x_q[a][s+1] <= x_q[a][s] - (y_q[a][s] >>> s);
            y_q[a][s+1] <= y_q[a][s] + (x_q[a][s] >>> s);
            z_q[a][s+1] <= z_q[a][s] - atan_lut(s);
          end else begin
            x_q[a][s+1] <= x_q[a][s] + (y_q[a][s] >>> s);
            y_q[a][s+1] <= y_q[a][s] - (x_q[a][s] >>> s);
            z_q[a][s+1] <= z_q[a][s] + atan_lut(s);
          end
          f_q[a][s+1] <= f_q[a][s];
          w_q[a][s+1] <= w_q[a][s];
        end
      end
      w_q[0][0] <= q_data_i.wx;
      w_q[1][0] <= q_data_i.wy;
      w_q[2][0] <= q_data_i.wz;
    end
  end

  // ---- trig fix-up ----
  trig_t sr_q, cr_q, sp_q, cp_q, sy_q, cy_q;
  logic signed [VectorBits-1:0] wa_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_q <= f_q[0][NS] ? -y_q[0][NS] : y_q[0][NS];
      cr_q <= f_q[0][NS] ? -x_q[0][NS] : x_q[0][NS];
      sp_q <= f_q[1][NS] ? -y_q[1][NS] : y_q[1][NS];
      cp_q <= f_q[1][NS] ? -x_q[1][NS] : x_q[1][NS];
      sy_q <= f_q[2][NS] ? -y_q[2][NS] : y_q[2][NS];
      cy_q <= f_q[2][NS] ? -x_q[2][NS] : x_q[2][NS];
      for (int a = 0; a < 3; a++) wa_q[a] <= w_q[a][NS];
    end
  end

  // ---- products stage 1: two-factor terms ----
  trig_t srsp_q, crsp_q, cpcy_q, cpsy_q, crsy_q, crcy_q, srcp_q, srsy_q, srcy_q;
  trig_t crcp_q, cy1_q, sy1_q, sp1_q;
  logic signed [VectorBits-1:0] wb_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      srsp_q <= mul_q30(sr_q, sp_q);
      crsp_q <= mul_q30(cr_q, sp_q);
      cpcy_q <= mul_q30(cp_q, cy_q);
      cpsy_q <= mul_q30(cp_q, sy_q);
      crsy_q <= mul_q30(cr_q, sy_q);
      crcy_q <= mul_q30(cr_q, cy_q);
      srcp_q <= mul_q30(sr_q, cp_q);
      srsy_q <= mul_q30(sr_q, sy_q);
      srcy_q <= mul_q30(sr_q, cy_q);
      crcp_q <= mul_q30(cr_q, cp_q);
      cy1_q  <= cy_q;
      sy1_q  <= sy_q;
      sp1_q  <= sp_q;
      for (int a = 0; a < 3; a++) wb_q[a] <= wa_q[a];
    end
  end

  // ---- products stage 2: coefficients ----
  trig_t m_q [9];
  logic signed [VectorBits-1:0] wc_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q[0] <= -cpcy_q;
      m_q[1] <= cpsy_q;
      m_q[2] <= sp1_q;
      m_q[3] <= -(mul_q30(srsp_q, cy1_q) - crsy_q);
      m_q[4] <= mul_q30(srsp_q, sy1_q) + crcy_q;
      m_q[5] <= -srcp_q;
      m_q[6] <= -(mul_q30(crsp_q, cy1_q) + srsy_q);
      m_q[7] <= mul_q30(crsp_q, sy1_q) - srcy_q;
      m_q[8] <= -crcp_q;
      for (int a = 0; a < 3; a++) wc_q[a] <= wb_q[a];
    end
  end

  // ---- coefficient times vector ----
  logic signed [ProdW-1:0] p_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) p_q[k] <= m_q[k] * wc_q[k % 3];
    end
  end

  // ---- row sums with rounding ----
  logic signed [AccW-1:0] acc_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= AccW'(p_q[3*r]) + AccW'(p_q[3*r+1]) + AccW'(p_q[3*r+2])
                  + (AccW'(1) <<< (TrigShift-1));
      end
    end
  end

  // ---- shift and saturate ----
  logic signed [AccW-TrigShift-1:0] sh [3];
  logic signed [VectorBits-1:0]     o_q [3];
  always_comb begin
    for (int r = 0; r < 3; r++) sh[r] = acc_q[r][AccW-1:TrigShift];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        if (sh[r] > (AccW-TrigShift)'(VMax))      o_q[r] <= VMax;
        else if (sh[r] < (AccW-TrigShift)'(VMin)) o_q[r] <= VMin;
        else                                       o_q[r] <= VectorBits'(sh[r]);
      end
    end
  end

  assign body_x_o = o_q[0];
  assign body_y_o = o_q[1];
  assign body_z_o = o_q[2];
endmodule
